>>> rtl/core/ordered_array_edit_engine_core_defines.svh
// Assertion macros shared by the ordered array edit engine RTL.
// Needs clk and rst_n in the scope of the module that expands them.
`ifndef ORDERED_ARRAY_EDIT_ENGINE_CORE_DEFINES_SVH
`define ORDERED_ARRAY_EDIT_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define OAEE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define OAEE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/oaee_pkg.sv
// Shared sizes, codes and bundle types for the ordered array edit engine.
// No dependencies; used by the controller and the top level.
`default_nettype none

package oaee_pkg;

  // Store size and derived widths
  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Fixed request and response field widths
  localparam int FUNC_W = 2;
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int ECNT_W = 5;

  // Width used to compare a position against the count
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT  = 2'd0,
    FN_DELETE  = 2'd1,
    FN_READ    = 2'd2,
    FN_REVERSE = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Finished response handed from the controller to the output stage
  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  read_value;
    logic        [ECNT_W-1:0]  entry_count;
  } res_t;

  // One memory access slot: one write and one read per cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

>>> rtl/core/oaee_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module oaee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; hold the last word when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/core/oaee_ctrl.sv
// Sequencer and shared index/compare datapath of the ordered array edit engine.
// Depends on oaee_pkg and the assertion macros header.
`default_nettype none

`include "ordered_array_edit_engine_core_defines.svh"

module oaee_ctrl (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  input  wire logic [oaee_pkg::FUNC_W-1:0]          in_func,
  input  wire logic [oaee_pkg::POS_W-1:0]           in_position,
  input  wire logic signed [oaee_pkg::DATA_W-1:0]   in_value,
  output logic                                      busy,
  output logic                                      res_valid,
  output oaee_pkg::res_t                            res,
  input  wire logic                                 res_take,
  output oaee_pkg::ram_req_t                        ram_req,
  input  wire logic [oaee_pkg::DATA_W-1:0]          ram_rdata
);

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_SCAN_RD   = 12'b0000_0000_0010,
    S_SCAN_CMP  = 12'b0000_0000_0100,
    S_MOVE_RD   = 12'b0000_0000_1000,
    S_MOVE_WR   = 12'b0000_0001_0000,
    S_INS_WR    = 12'b0000_0010_0000,
    S_READ_WAIT = 12'b0000_0100_0000,
    S_REV_RD_LO = 12'b0000_1000_0000,
    S_REV_RD_HI = 12'b0001_0000_0000,
    S_REV_WR_LO = 12'b0010_0000_0000,
    S_REV_WR_HI = 12'b0100_0000_0000,
    S_DONE      = 12'b1000_0000_0000
  } state_t;

  state_t                            state_r,  state_nxt;
  oaee_pkg::func_t                   op_r,     op_nxt;
  logic [oaee_pkg::POS_W-1:0]        pos_r,    pos_nxt;
  logic [oaee_pkg::DATA_W-1:0]       key_r,    key_nxt;
  logic [oaee_pkg::CNT_W-1:0]        idx_r,    idx_nxt;
  logic [oaee_pkg::CNT_W-1:0]        hi_r,     hi_nxt;
  logic [oaee_pkg::CNT_W-1:0]        cnt_r,    cnt_nxt;
  logic [oaee_pkg::DATA_W-1:0]       tmp_r,    tmp_nxt;
  oaee_pkg::status_t                 status_r, status_nxt;
  logic [oaee_pkg::DATA_W-1:0]       rd_r,     rd_nxt;

  // Shared index arithmetic
  logic [oaee_pkg::CNT_W-1:0] idx_inc, idx_dec, hi_dec;
  logic [oaee_pkg::CMP_W-1:0] in_pos_x, pos_x, cnt_x, idx_dec_x;

  assign idx_inc   = idx_r + 1'b1;
  assign idx_dec   = idx_r - 1'b1;
  assign hi_dec    = hi_r - 1'b1;
  assign in_pos_x  = (oaee_pkg::CMP_W)'(in_position);
  assign pos_x     = (oaee_pkg::CMP_W)'(pos_r);
  assign cnt_x     = (oaee_pkg::CMP_W)'(cnt_r);
  assign idx_dec_x = (oaee_pkg::CMP_W)'(idx_dec);

  // Next-state and datapath control
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    pos_nxt    = pos_r;
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    hi_nxt     = hi_r;
    cnt_nxt    = cnt_r;
    tmp_nxt    = tmp_r;
    status_nxt = status_r;
    rd_nxt     = rd_r;
    ram_req    = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = oaee_pkg::func_t'(in_func);
          pos_nxt    = in_position;
          key_nxt    = in_value;
          status_nxt = oaee_pkg::ST_OK;
          rd_nxt     = '0;
          case (oaee_pkg::func_t'(in_func))
            oaee_pkg::FN_INSERT: begin
              if (in_pos_x > cnt_x) begin
                status_nxt = oaee_pkg::ST_BAD_POS;
                state_nxt  = S_DONE;
              end else if (cnt_r == (oaee_pkg::CNT_W)'(oaee_pkg::DEPTH)) begin
                status_nxt = oaee_pkg::ST_FULL;
                state_nxt  = S_DONE;
              end else if (cnt_x > in_pos_x) begin
                idx_nxt   = cnt_r;
                state_nxt = S_MOVE_RD;
              end else begin
                state_nxt = S_INS_WR;
              end
            end
            oaee_pkg::FN_DELETE: begin
              if (cnt_r == '0) begin
                status_nxt = oaee_pkg::ST_NOT_FOUND;
                state_nxt  = S_DONE;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SCAN_RD;
              end
            end
            oaee_pkg::FN_READ: begin
              if (in_pos_x < cnt_x) begin
                ram_req.re    = 1'b1;
                ram_req.raddr = (oaee_pkg::ADDR_W)'(in_position);
                state_nxt     = S_READ_WAIT;
              end else begin
                status_nxt = oaee_pkg::ST_BAD_POS;
                state_nxt  = S_DONE;
              end
            end
            oaee_pkg::FN_REVERSE: begin
              if (cnt_r < (oaee_pkg::CNT_W)'(2)) begin
                state_nxt = S_DONE;
              end else begin
                idx_nxt   = '0;
                hi_nxt    = cnt_r - 1'b1;
                state_nxt = S_REV_RD_LO;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Search for the first matching key, reading and then comparing each entry in turn
      S_SCAN_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = idx_r[oaee_pkg::ADDR_W-1:0];
        state_nxt     = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (ram_rdata == key_r) begin
          if (idx_inc < cnt_r) begin
            idx_nxt   = idx_inc;
            state_nxt = S_MOVE_RD;
          end else begin
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = S_DONE;
          end
        end else if (idx_inc < cnt_r) begin
          idx_nxt   = idx_inc;
          state_nxt = S_SCAN_RD;
        end else begin
          status_nxt = oaee_pkg::ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end
      end

      // Shift one entry: up for insert, down for delete
      S_MOVE_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = (op_r == oaee_pkg::FN_INSERT) ? idx_dec[oaee_pkg::ADDR_W-1:0]
                                                      : idx_r[oaee_pkg::ADDR_W-1:0];
        state_nxt     = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = ram_rdata;
        if (op_r == oaee_pkg::FN_INSERT) begin
          ram_req.waddr = idx_r[oaee_pkg::ADDR_W-1:0];
          idx_nxt       = idx_dec;
          state_nxt     = (idx_dec_x > pos_x) ? S_MOVE_RD : S_INS_WR;
        end else begin
          ram_req.waddr = idx_dec[oaee_pkg::ADDR_W-1:0];
          if (idx_inc < cnt_r) begin
            idx_nxt   = idx_inc;
            state_nxt = S_MOVE_RD;
          end else begin
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = S_DONE;
          end
        end
      end

      // Drop the new value into the opened slot
      S_INS_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = (oaee_pkg::ADDR_W)'(pos_r);
        ram_req.wdata = key_r;
        cnt_nxt       = cnt_r + 1'b1;
        state_nxt     = S_DONE;
      end

      S_READ_WAIT: begin
        rd_nxt    = ram_rdata;
        state_nxt = S_DONE;
      end

      // Swap the outer pair, then advance both pointers inward
      S_REV_RD_LO: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = idx_r[oaee_pkg::ADDR_W-1:0];
        state_nxt     = S_REV_RD_HI;
      end

      S_REV_RD_HI: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = hi_r[oaee_pkg::ADDR_W-1:0];
        tmp_nxt       = ram_rdata;
        state_nxt     = S_REV_WR_LO;
      end

      S_REV_WR_LO: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r[oaee_pkg::ADDR_W-1:0];
        ram_req.wdata = ram_rdata;
        state_nxt     = S_REV_WR_HI;
      end

      S_REV_WR_HI: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = hi_r[oaee_pkg::ADDR_W-1:0];
        ram_req.wdata = tmp_r;
        idx_nxt       = idx_inc;
        hi_nxt        = hi_dec;
        state_nxt     = (idx_inc < hi_dec) ? S_REV_RD_LO : S_DONE;
      end

      // Hold the response until the output stage takes it
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    pos_r    <= pos_nxt;
    key_r    <= key_nxt;
    idx_r    <= idx_nxt;
    hi_r     <= hi_nxt;
    tmp_r    <= tmp_nxt;
    status_r <= status_nxt;
    rd_r     <= rd_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign res_valid           = (state_r == S_DONE);
  assign res.status          = status_r;
  assign res.read_value      = rd_r;
  assign res.entry_count     = (oaee_pkg::ECNT_W)'(cnt_r);

  `OAEE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= (oaee_pkg::CNT_W)'(oaee_pkg::DEPTH), "count above depth")
  `OAEE_ASSERT_IMP(a_cnt_step, $past(rst_n), (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + 1'b1) || (cnt_r + 1'b1 == $past(cnt_r)), "count moved by more than one")
  `OAEE_ASSERT_IMP(a_wr_range, ram_req.we, ram_req.waddr <= cnt_r, "write beyond the used region")
  `OAEE_ASSERT_IMP(a_rev_order, (state_r == S_REV_RD_LO) || (state_r == S_REV_RD_HI) || (state_r == S_REV_WR_LO) || (state_r == S_REV_WR_HI), idx_r < hi_r, "reverse pointers crossed")
  `OAEE_ASSERT_NXT(a_accept_busy, (state_r == S_IDLE) && in_valid, state_r != S_IDLE, "accepted request did not start")

endmodule

`default_nettype wire

>>> rtl/core/ordered_array_edit_engine_core.sv
// Ordered array edit engine: top level with the entry store, the sequencer and the result register.
// Depends on oaee_pkg, oaee_ram and oaee_ctrl.
//
// Keeps up to oaee_pkg::DEPTH signed 32-bit entries in positions 0..count-1 and applies one
// request at a time: insert at a position, delete the first entry equal to a key, read at a
// position, or reverse the entries in use. Every request gives exactly one response with a
// status, the read value (zero unless a read succeeds) and the new count. All entry traffic goes
// through one store with one write and one registered read per cycle, so the engine is busy
// (in_stall high) for the whole request: a read is one store read, an insert moves each entry
// from the position up by one and then writes the new value, a delete scans for the key and
// moves each later entry down by one, and a reverse swaps pairs from the ends inward. The finished
// response sits in an output register, so the next request is taken while it waits for the sink.
`default_nettype none

module ordered_array_edit_engine_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [oaee_pkg::FUNC_W-1:0]         in_func,
  input  wire logic [oaee_pkg::POS_W-1:0]          in_position,
  input  wire logic signed [oaee_pkg::DATA_W-1:0]  in_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [oaee_pkg::STAT_W-1:0]              out_status,
  output logic signed [oaee_pkg::DATA_W-1:0]       out_read_value,
  output logic [oaee_pkg::ECNT_W-1:0]              out_entry_count
);

  logic                          busy;
  logic                          res_valid;
  logic                          res_take;
  oaee_pkg::res_t                res;
  oaee_pkg::ram_req_t            ram_req;
  logic [oaee_pkg::DATA_W-1:0]   ram_rdata;

  logic                          out_valid_r, out_valid_nxt;
  oaee_pkg::res_t                out_res_r;

  // Entry store
  oaee_ram #(
    .WIDTH (oaee_pkg::DATA_W),
    .DEPTH (oaee_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Request sequencer
  oaee_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_func     (in_func),
    .in_position (in_position),
    .in_value    (in_value),
    .busy        (busy),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata)
  );

  assign in_stall = busy;

  // Load the response register when it is empty or being drained
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_read_value  = out_res_r.read_value;
  assign out_entry_count = out_res_r.entry_count;

endmodule

`default_nettype wire
